### rtl/core/uri_scheme_host_port_parser_defines.svh
// Assertion macros used by the checker file of the URI parser.
`ifndef URI_SCHEME_HOST_PORT_PARSER_DEFINES_SVH
`define URI_SCHEME_HOST_PORT_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define USHP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define USHP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/ushp_pkg.sv
// Types, constants and codes of the URI scheme/host/port parser.
`default_nettype none

package ushp_pkg;

  localparam int unsigned MAX_SCHEME = 32;
  localparam int unsigned MAX_HOST   = 255;

  localparam int unsigned CAP_W       = 9;
  localparam int unsigned CFG_AW      = 3;
  localparam int unsigned CFG_DW      = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  localparam logic [2:0] CLOSE_GAP_MAX = 3'd5;
  localparam logic [3:0] CLOSE_LIMIT   = 4'd8;

  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CW    = $clog2(OQ_DEPTH + 1);

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;

  typedef enum logic [3:0] {
    PH_SCHEME   = 4'd0,
    PH_SEP1     = 4'd1,
    PH_SEP2     = 4'd2,
    PH_SEP3     = 4'd3,
    PH_HOST4    = 4'd4,
    PH_HOST6    = 4'd5,
    PH_PORT_WS  = 4'd6,
    PH_PORT_DIG = 4'd7,
    PH_PORT_END = 4'd8,
    PH_DEAD     = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_SCHEME = 2'd1,
    KIND_HOST   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_NO_COLON     = 3'd1,
    ERR_SCHEME_LONG  = 3'd2,
    ERR_BAD_SEP      = 3'd3,
    ERR_CLOSE_COLONS = 3'd4,
    ERR_NO_HOST_END  = 3'd5,
    ERR_HOST_LONG    = 3'd6
  } err_t;

  typedef enum logic [0:0] {
    REG_SCHEME_CAP = 1'b0,
    REG_HOST_CAP   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] character;
    logic       final_char;
  } in_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  text_byte;
    logic        run_end;
    logic        done_res;
    logic        ok;
    err_t        error_code;
    logic [15:0] port_value;
  } out_t;

  typedef struct packed {
    phase_t      phase;
    logic [8:0]  scheme_count;
    logic [8:0]  host_count;
    logic        bracket_held;
    logic        bracket_form;
    logic [2:0]  colon_gap;
    logic [3:0]  close_colons;
    logic [15:0] port_accum;
    logic        port_negative;
    logic [5:0]  error_flags;
  } state_t;

  // Results of one character going into the output queue.
  typedef struct packed {
    logic [1:0] cnt;
    out_t       r0;
    out_t       r1;
  } push_t;

  localparam state_t STATE_RESET = '{
    phase:         PH_SCHEME,
    scheme_count:  9'd0,
    host_count:    9'd0,
    bracket_held:  1'b0,
    bracket_form:  1'b0,
    colon_gap:     3'd7,
    close_colons:  4'd1,
    port_accum:    16'd0,
    port_negative: 1'b0,
    error_flags:   6'd0
  };

endpackage

`default_nettype wire

### rtl/core/ushp_step.sv
// Per-character parse step: next state and up to two results.
`default_nettype none

module ushp_step import ushp_pkg::*; (
  input  state_t           st,
  input  in_t              item,
  input  logic [CAP_W-1:0] scheme_cap,
  input  logic [CAP_W-1:0] host_cap,
  output state_t           st_nxt,
  output push_t            push
);

  state_t      s;
  out_t        res [2];
  logic [1:0]  n;
  logic [7:0]  c;
  logic        go_dig;
  logic        is_ws;
  logic        is_digit;
  err_t        code;
  logic        last;

  function automatic out_t mk(input kind_t k, input logic [7:0] b);
    out_t r;
    r = '0;
    r.kind = k;
    r.text_byte = b;
    return r;
  endfunction

  function automatic logic [8:0] sat_inc(input logic [8:0] v);
    return (v == 9'h1FF) ? v : v + 9'd1;
  endfunction

  // Length must stay below the buffer size and within the hard limit.
  function automatic logic too_long(input logic [8:0] cnt, input logic [8:0] cap,
                                    input logic [8:0] lim);
    return (cnt > lim) || (({1'b0, cnt} + 10'd1) > {1'b0, cap});
  endfunction

  assign c        = item.character;
  assign is_ws    = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);

  always_comb begin
    s      = st;
    n      = 2'd0;
    res[0] = '0;
    res[1] = '0;
    go_dig = 1'b0;
    code   = ERR_NONE;
    last   = 1'b0;

    if (c == CH_COLON) begin
      if ((s.colon_gap <= CLOSE_GAP_MAX) && (s.close_colons < CLOSE_LIMIT)) begin
        s.close_colons = s.close_colons + 4'd1;
      end
      s.colon_gap = 3'd0;
    end else if (s.colon_gap != 3'd7) begin
      s.colon_gap = s.colon_gap + 3'd1;
    end

    unique case (s.phase)
      PH_SCHEME: begin
        if (c == CH_COLON) begin
          res[n[0]] = mk(KIND_NONE, c);
          n = n + 2'd1;
          if (too_long(s.scheme_count, scheme_cap, 9'(MAX_SCHEME))) begin
            s.error_flags[1] = 1'b1;
          end
          s.phase = PH_SEP1;
        end else begin
          res[n[0]] = mk(KIND_SCHEME, c);
          n = n + 2'd1;
          s.scheme_count = sat_inc(s.scheme_count);
        end
      end
      PH_SEP1, PH_SEP2: begin
        res[n[0]] = mk(KIND_NONE, c);
        n = n + 2'd1;
        if (c == CH_SLASH) begin
          s.phase = (s.phase == PH_SEP1) ? PH_SEP2 : PH_SEP3;
        end else begin
          s.error_flags[2] = 1'b1;
          s.phase = PH_DEAD;
        end
      end
      PH_SEP3, PH_HOST4: begin
        if ((s.phase == PH_SEP3) && (c == CH_LBRACK)) begin
          s.bracket_form = 1'b1;
          s.phase = PH_HOST6;
          res[n[0]] = mk(KIND_NONE, c);
          n = n + 2'd1;
        end else begin
          s.phase = PH_HOST4;
          if (c == CH_COLON) begin
            res[n[0]] = mk(KIND_NONE, c);
            n = n + 2'd1;
            if (too_long(s.host_count, host_cap, 9'(MAX_HOST))) s.error_flags[5] = 1'b1;
            s.phase = PH_PORT_WS;
          end else begin
            res[n[0]] = mk(KIND_HOST, c);
            n = n + 2'd1;
            s.host_count = sat_inc(s.host_count);
          end
        end
      end
      PH_HOST6: begin
        if (s.bracket_held && (c == CH_COLON)) begin
          // "]:" closes the bracketed host
          s.bracket_held = 1'b0;
          res[0] = mk(KIND_NONE, CH_RBRACK);
          res[1] = mk(KIND_NONE, c);
          n = 2'd2;
          if (too_long(s.host_count, host_cap, 9'(MAX_HOST))) s.error_flags[5] = 1'b1;
          s.phase = PH_PORT_WS;
        end else begin
          if (s.bracket_held) begin
            s.bracket_held = 1'b0;
            res[n[0]] = mk(KIND_HOST, CH_RBRACK);
            n = n + 2'd1;
            s.host_count = sat_inc(s.host_count);
          end
          if (c == CH_RBRACK) begin
            s.bracket_held = 1'b1;
          end else begin
            res[n[0]] = mk(KIND_HOST, c);
            n = n + 2'd1;
            s.host_count = sat_inc(s.host_count);
          end
        end
      end
      PH_PORT_WS, PH_PORT_DIG, PH_PORT_END: begin
        if (s.phase == PH_PORT_WS) begin
          priority if (is_ws) begin
          end else if (c == CH_PLUS) begin
            s.phase = PH_PORT_DIG;
          end else if (c == CH_MINUS) begin
            s.port_negative = 1'b1;
            s.phase = PH_PORT_DIG;
          end else begin
            s.phase = PH_PORT_DIG;
            go_dig = 1'b1;
          end
        end else if (s.phase == PH_PORT_DIG) begin
          go_dig = 1'b1;
        end
        if (go_dig) begin
          if (is_digit) begin
            s.port_accum = {s.port_accum[12:0], 3'b000} + {s.port_accum[14:0], 1'b0}
                         + {12'd0, c[3:0]};
          end else begin
            s.phase = PH_PORT_END;
          end
        end
        res[n[0]] = mk(KIND_NONE, c);
        n = n + 2'd1;
      end
      default: begin
        res[n[0]] = mk(KIND_NONE, c);
        n = n + 2'd1;
      end
    endcase

    if (item.final_char) begin
      if (s.bracket_held) begin
        s.bracket_held = 1'b0;
        res[n[0]] = mk(KIND_HOST, CH_RBRACK);
        n = n + 2'd1;
        s.host_count = sat_inc(s.host_count);
      end
      if (s.phase == PH_SCHEME) s.error_flags[0] = 1'b1;
      if ((s.phase == PH_SEP1) || (s.phase == PH_SEP2)) s.error_flags[2] = 1'b1;
      if ((s.phase == PH_SEP3) || (s.phase == PH_HOST4) || (s.phase == PH_HOST6)) begin
        s.error_flags[4] = 1'b1;
      end
      if (!s.bracket_form && (s.close_colons >= CLOSE_LIMIT) &&
          ((s.phase == PH_SEP3) || (s.phase == PH_HOST4) || (s.phase == PH_HOST6) ||
           (s.phase == PH_PORT_WS) || (s.phase == PH_PORT_DIG) ||
           (s.phase == PH_PORT_END))) begin
        s.error_flags[3] = 1'b1;
      end
      // lowest flag wins
      for (int k = 5; k >= 0; k--) begin
        if (s.error_flags[k]) code = err_t'(3'(k + 1));
      end
      last = n[1];
      res[last].done_res   = 1'b1;
      res[last].ok         = (code == ERR_NONE);
      res[last].error_code = code;
      if (code == ERR_NONE) begin
        res[last].port_value = s.port_negative ? 16'(~s.port_accum + 16'd1) : s.port_accum;
      end
      s = STATE_RESET;
    end

    if (n != 2'd0) res[n[1]].run_end = 1'b1;
  end

  assign st_nxt   = s;
  assign push.cnt = n;
  assign push.r0  = res[0];
  assign push.r1  = res[1];

endmodule

`default_nettype wire

### rtl/core/ushp_outq.sv
// Result queue: takes up to two results a cycle, hands out one unless out_stall is high.
`default_nettype none

module ushp_outq import ushp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  room,
  output logic  out_valid,
  input  logic  out_stall,
  output out_t  out_data
);

  out_t             q_r [OQ_DEPTH];
  logic [OQ_AW-1:0] wp_r, wp_nxt;
  logic [OQ_AW-1:0] rp_r, rp_nxt;
  logic [OQ_CW-1:0] cnt_r, cnt_nxt;
  logic             pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = q_r[rp_r];
  assign pop       = out_valid && !out_stall;
  // space for the two results a single character can cause
  assign room      = (cnt_r <= OQ_CW'(OQ_DEPTH - 2));

  always_comb begin
    wp_nxt  = wp_r + OQ_AW'(push.cnt);
    rp_nxt  = pop ? rp_r + OQ_AW'(1) : rp_r;
    cnt_nxt = cnt_r + OQ_CW'(push.cnt) - OQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) q_r[wp_r] <= push.r0;
    if (push.cnt == 2'd2) q_r[wp_r + OQ_AW'(1)] <= push.r1;
  end

endmodule

`default_nettype wire

### rtl/core/uri_scheme_host_port_parser.sv
// URI scheme/host/port parser, top level: input register, parse step, result queue, config.
//
// Takes one URI character per cycle and tags it as scheme, host or other; the
// last result of the final character carries ok, a prioritized error code and
// the port (atoi, modulo 65536). One character is accepted every cycle while the
// four-entry result queue has room for two results; the queue hands out one result
// at a time, so a character that yields two results (a held ']' released together
// with the next character) slows a sustained stream. A ']' inside a bracketed host
// yields nothing until the next character arrives, unless it is final. An accepted
// character is registered, and its results are queued, before out_valid. Registers:
// 0x0 scheme_capacity, 0x4 host_capacity (9 bits, reset 256); the user must write
// them only while no transaction is in flight, which the block does not enforce.
`default_nettype none

module uri_scheme_host_port_parser import ushp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_t              out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  logic             in_vld_r, in_vld_nxt;
  in_t              in_data_r;
  state_t           state_r, state_nxt;
  logic [CAP_W-1:0] scheme_cap_r, host_cap_r;
  push_t            step_push, push;
  logic             room, adv, accept, cfg_wr;
  reg_idx_t         reg_idx;

  assign pready   = 1'b1;
  assign reg_idx  = reg_idx_t'(paddr[2]);
  assign cfg_wr   = psel && penable && pwrite;

  assign adv      = in_vld_r && room;
  assign in_stall = in_vld_r && !room;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = accept ? 1'b1 : (adv ? 1'b0 : in_vld_r);
    push       = step_push;
    if (!adv) push.cnt = 2'd0;
  end

  always_comb begin
    unique case (reg_idx)
      REG_SCHEME_CAP: prdata = {{(CFG_DW - CAP_W){1'b0}}, scheme_cap_r};
      REG_HOST_CAP:   prdata = {{(CFG_DW - CAP_W){1'b0}}, host_cap_r};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      state_r      <= STATE_RESET;
      scheme_cap_r <= CAP_RESET;
      host_cap_r   <= CAP_RESET;
    end else begin
      in_vld_r <= in_vld_nxt;
      if (adv) state_r <= state_nxt;
      if (cfg_wr) begin
        unique case (reg_idx)
          REG_SCHEME_CAP: scheme_cap_r <= pwdata[CAP_W-1:0];
          REG_HOST_CAP:   host_cap_r   <= pwdata[CAP_W-1:0];
          default:        ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) in_data_r <= in_data;
  end

  ushp_step u_step (
    .st         (state_r),
    .item       (in_data_r),
    .scheme_cap (scheme_cap_r),
    .host_cap   (host_cap_r),
    .st_nxt     (state_nxt),
    .push       (step_push)
  );

  ushp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### rtl/core/ushp_checker.sv
// Port-level checks on the parser's result channel, bound to the top level.
`default_nettype none
`include "uri_scheme_host_port_parser_defines.svh"

module ushp_checker import ushp_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  `USHP_ASSERT_NXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(out_data), "result changed while stalled")
  `USHP_ASSERT_NOW(a_verdict_last, out_valid && out_data.done_res,
                   out_data.run_end && (out_data.ok == (out_data.error_code == ERR_NONE)),
                   "verdict not on last result or ok/code mismatch")
  `USHP_ASSERT_NOW(a_plain_zero, out_valid && !out_data.done_res,
                   !out_data.ok && (out_data.error_code == ERR_NONE) &&
                   (out_data.port_value == 16'd0), "verdict fields set on plain result")
  `USHP_ASSERT_NOW(a_fail_port, out_valid && out_data.done_res && !out_data.ok,
                   out_data.port_value == 16'd0, "port reported on failed parse")

endmodule

bind uri_scheme_host_port_parser ushp_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
